FILE: rtl/core/grt_pkg.sv
package grt_pkg;

   // Defaults for the top-level parameters.
   localparam int TILE_PIXELS_DEF = 32;
   localparam int MAX_COLS_DEF    = 64;
   localparam int MAX_ROWS_DEF    = 64;

   // Configuration port.
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0]  CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_DATA_W-1:0] MAP_SIZE_RESET = 7'd64;

   // Fixed-point and datapath widths.
   localparam int FRAC_BITS  = 30;
   localparam int COORD_W    = 16;
   localparam int DIV_DEN_W  = 16;
   localparam int TILE_IDX_W = 18;

   // How the front end classifies a transaction.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_DROP  = 2'd1,
      KIND_CAST  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [5:0]                 col;
      logic [5:0]                 row;
      logic                       solid;
      logic [COORD_W-1:0]         origin_x;
      logic [COORD_W-1:0]         origin_y;
      logic signed [COORD_W-1:0]  dir_x;
      logic signed [COORD_W-1:0]  dir_y;
   } item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

FILE: rtl/core/grt_front.sv
module grt_front #(
   parameter int MAX_COLS = grt_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = grt_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [5:0]                    req_tile_col,
   input  logic [5:0]                    req_tile_row,
   input  logic                          req_tile_solid,
   input  logic [15:0]                   req_origin_x,
   input  logic [15:0]                   req_origin_y,
   input  logic signed [15:0]            req_dir_x,
   input  logic signed [15:0]            req_dir_y,
   output grt_pkg::queue_out_type        q_out,
   input  logic                          q_pop
);
   import grt_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item_in;
   logic       push;

   // Classify the incoming transaction.
   always_comb begin
      item_in          = '0;
      item_in.col      = req_tile_col;
      item_in.row      = req_tile_row;
      item_in.solid    = req_tile_solid;
      item_in.origin_x = req_origin_x;
      item_in.origin_y = req_origin_y;
      item_in.dir_x    = req_dir_x;
      item_in.dir_y    = req_dir_y;
      if (req_mode) begin
         item_in.kind = KIND_CAST;
      end else if ((32'(req_tile_col) < MAX_COLS) && (32'(req_tile_row) < MAX_ROWS)) begin
         item_in.kind = KIND_WRITE;
      end else begin
         item_in.kind = KIND_DROP;
      end
   end

   assign req_ready   = (count_ff != 2'd2) && !hold;
   assign push        = req_valid && req_ready;
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   // Two-entry queue pointers.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/core/grt_div.sv
module grt_div #(
   parameter int NW = 40,
   parameter int DW = 16,
   parameter int CW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [CW-1:0] iters,
   output logic          busy,
   output logic [NW-1:0] quo
);
   logic [NW-1:0] num_ff, quo_ff;
   logic [DW-1:0] den_ff, rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [DW:0]   trial;
   logic          fits;

   // One restoring step per cycle, numerator bits taken from the top.
   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= iters;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != 1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/core/grt_back.sv
module grt_back #(
   parameter int TILE_PIXELS = grt_pkg::TILE_PIXELS_DEF,
   parameter int MAX_COLS    = grt_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = grt_pkg::MAX_ROWS_DEF,
   parameter int WB          = $clog2(MAX_COLS + 1),
   parameter int HB          = $clog2(MAX_ROWS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WB-1:0]          map_cols,
   input  logic [HB-1:0]          map_rows,
   input  grt_pkg::queue_out_type q_out,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [15:0]            rsp_end_x,
   output logic [15:0]            rsp_end_y
);
   import grt_pkg::*;

   localparam int T     = TILE_PIXELS * 16;
   localparam int TB    = $clog2(T + 1);
   localparam int NW    = TB + FRAC_BITS;
   localparam int CW    = $clog2(NW + 1);
   localparam int TW    = NW + $clog2(MAX_COLS + MAX_ROWS + 1) + 1;
   localparam int HALF  = (TW + 1) / 2;
   localparam int PW    = HALF + DIV_DEN_W;
   localparam int AW2   = TW + DIV_DEN_W;
   localparam int OW    = AW2 - FRAC_BITS;
   localparam int EW    = OW + 2;
   localparam int XW    = TILE_IDX_W;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // Reciprocal of the tile size, exact for every 16-bit origin.
   localparam int SH    = $clog2(T);
   localparam int RS    = 16 + SH;
   localparam int RW    = 18;
   localparam int PRW   = 16 + RW;
   localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / T + 1);

   localparam logic [2:0] PH_TILE_X  = 3'd0;
   localparam logic [2:0] PH_TILE_Y  = 3'd1;
   localparam logic [2:0] PH_TMAX_X  = 3'd2;
   localparam logic [2:0] PH_DELTA_X = 3'd3;
   localparam logic [2:0] PH_TMAX_Y  = 3'd4;
   localparam logic [2:0] PH_DELTA_Y = 3'd5;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b00_0000_0001,
      S_IDLE    = 10'b00_0000_0010,
      S_DIVGO   = 10'b00_0000_0100,
      S_DIVWAIT = 10'b00_0000_1000,
      S_READ    = 10'b00_0001_0000,
      S_TEST    = 10'b00_0010_0000,
      S_MUL     = 10'b00_0100_0000,
      S_ACC     = 10'b00_1000_0000,
      S_END     = 10'b01_0000_0000,
      S_OUT     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]  phase_ff, phase_in, phase_next;
   logic [1:0]  mstep_ff;
   logic [AW-1:0] clr_ff;

   // Current cast.
   logic [15:0]         ox_ff, oy_ff;
   logic                negx_ff, negy_ff;
   logic [15:0]         magx_ff, magy_ff;
   logic [TB-1:0]       remx_ff, remy_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic [TW-1:0]       tmx_ff, tmy_ff, dlx_ff, dly_ff, t_ff;
   logic                hit_ff;
   logic [PW-1:0]       prod_ff;
   logic [AW2-1:0]      accx_ff, accy_ff;
   logic [15:0]         endx_ff, endy_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [15:0]         rsp_end_x_ff, rsp_end_y_ff;

   // Tile memory.
   logic                mem [CELLS];
   logic                rd_ff;
   logic                mem_we, mem_wdata;
   logic [AW-1:0]       mem_waddr, mem_raddr;

   // Divider hookup.
   logic                div_start, div_busy;
   logic [NW-1:0]       div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;
   logic [CW-1:0]       div_iters;

   // Starting tile of the cast at the queue head.
   logic [PRW-1:0]      tprod_x, tprod_y;
   logic [15:0]         tile_x, tile_y;
   logic [TB-1:0]       trem_x, trem_y;

   logic                movx, movy, oob, step_x, out_free;
   logic [TB-1:0]       distx, disty;
   logic [15:0]         dmag_x, dmag_y;
   logic [HALF-1:0]     mul_part;
   logic [15:0]         mul_mag;
   logic [AW2-1:0]      acc_sum;
   logic [OW-1:0]       offx, offy;
   logic signed [EW-1:0] ex, ey;

   assign movx     = (magx_ff != '0);
   assign movy     = (magy_ff != '0);
   assign distx    = negx_ff ? remx_ff : TB'(T - 32'(remx_ff));
   assign disty    = negy_ff ? remy_ff : TB'(T - 32'(remy_ff));
   assign dmag_x   = q_out.item.dir_x[15] ? 16'(-q_out.item.dir_x) : q_out.item.dir_x;
   assign dmag_y   = q_out.item.dir_y[15] ? 16'(-q_out.item.dir_y) : q_out.item.dir_y;
   assign clearing = (state_ff == S_CLEAR);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Tile index and offset within the tile, by reciprocal multiplication.
   assign tprod_x = PRW'(q_out.item.origin_x) * PRW'(RECIP);
   assign tprod_y = PRW'(q_out.item.origin_y) * PRW'(RECIP);
   assign tile_x  = 16'(tprod_x >> RS);
   assign tile_y  = 16'(tprod_y >> RS);
   assign trem_x  = TB'(q_out.item.origin_x - 16'(32'(tile_x) * T));
   assign trem_y  = TB'(q_out.item.origin_y - 16'(32'(tile_y) * T));

   assign oob = x_ff[XW-1] || y_ff[XW-1]
             || (x_ff >= $signed({{(XW-WB){1'b0}}, map_cols}))
             || (y_ff >= $signed({{(XW-HB){1'b0}}, map_rows}));
   assign step_x = movx && (!movy || (tmx_ff < tmy_ff));
   assign mem_raddr = AW'(32'(y_ff[RB-1:0]) * MAX_COLS + 32'(x_ff[CB-1:0]));

   // Next divide phase, skipping the axis that never moves.
   always_comb begin
      phase_next = phase_ff + 3'd1;
      if ((phase_next == PH_TMAX_X) && !movx) begin
         phase_next = PH_TMAX_Y;
      end
      if ((phase_next == PH_TMAX_Y) && !movy) begin
         phase_next = PH_DELTA_Y + 3'd1;
      end
   end

   // Divider operands for each phase.
   always_comb begin
      div_num   = '0;
      div_den   = DIV_DEN_W'(T);
      div_iters = CW'(NW);
      unique case (phase_ff)
         PH_TMAX_X: begin
            div_num = {distx, {FRAC_BITS{1'b0}}};
            div_den = magx_ff;
         end
         PH_DELTA_X: begin
            div_num = {TB'(T), {FRAC_BITS{1'b0}}};
            div_den = magx_ff;
         end
         PH_TMAX_Y: begin
            div_num = {disty, {FRAC_BITS{1'b0}}};
            div_den = magy_ff;
         end
         PH_DELTA_Y: begin
            div_num = {TB'(T), {FRAC_BITS{1'b0}}};
            div_den = magy_ff;
         end
         default: begin
            div_num = '0;
         end
      endcase
   end

   assign div_start = (state_ff == S_DIVGO);

   grt_div #(
      .NW (NW),
      .DW (DIV_DEN_W),
      .CW (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // Endpoint multiply operands: low or high half of t, x axis then y axis.
   assign mul_part = mstep_ff[0] ? HALF'(t_ff[TW-1:HALF]) : t_ff[HALF-1:0];
   assign mul_mag  = mstep_ff[1] ? magy_ff : magx_ff;
   assign acc_sum  = mstep_ff[0]
                   ? ((mstep_ff[1] ? accy_ff : accx_ff) + (AW2'(prod_ff) << HALF))
                   : AW2'(prod_ff);

   // Endpoint offsets and endpoints before clamping.
   assign offx = OW'(accx_ff >> FRAC_BITS);
   assign offy = OW'(accy_ff >> FRAC_BITS);
   assign ex   = negx_ff ? ($signed(EW'(ox_ff)) - $signed(EW'(offx)))
                         : ($signed(EW'(ox_ff)) + $signed(EW'(offx)));
   assign ey   = negy_ff ? ($signed(EW'(oy_ff)) - $signed(EW'(offy)))
                         : ($signed(EW'(oy_ff)) + $signed(EW'(offy)));

   // Control sequencer.
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop = 1'b1;
               unique case (q_out.item.kind)
                  KIND_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(32'(q_out.item.row) * MAX_COLS + 32'(q_out.item.col));
                     mem_wdata = q_out.item.solid;
                  end
                  KIND_CAST: begin
                     // The starting tile is already known; DIVWAIT picks the first divide, if any, next.
                     phase_in = PH_TILE_Y;
                     state_in = S_DIVWAIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (!div_busy) begin
               if (phase_next > PH_DELTA_Y) begin
                  state_in = S_READ;
               end else begin
                  phase_in = phase_next;
                  state_in = S_DIVGO;
               end
            end
         end
         S_READ: begin
            state_in = oob ? S_MUL : S_TEST;
         end
         S_TEST: begin
            if (rd_ff || (!movx && !movy)) begin
               state_in = S_MUL;
            end else begin
               state_in = S_READ;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = (mstep_ff == 2'd3) ? S_END : S_MUL;
         end
         S_END: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= PH_TILE_X;
         mstep_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == S_ACC) begin
            mstep_ff <= mstep_ff + 2'd1;
         end
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers for the cast in flight.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            ox_ff   <= q_out.item.origin_x;
            oy_ff   <= q_out.item.origin_y;
            negx_ff <= q_out.item.dir_x[15];
            negy_ff <= q_out.item.dir_y[15];
            magx_ff <= dmag_x;
            magy_ff <= dmag_y;
            x_ff    <= $signed({{(XW-16){1'b0}}, tile_x});
            y_ff    <= $signed({{(XW-16){1'b0}}, tile_y});
            remx_ff <= trem_x;
            remy_ff <= trem_y;
            t_ff    <= '0;
            hit_ff  <= 1'b0;
         end
         S_DIVWAIT: begin
            if (!div_busy) begin
               unique case (phase_ff)
                  PH_TMAX_X:  tmx_ff <= TW'(div_quo);
                  PH_DELTA_X: dlx_ff <= TW'(div_quo);
                  PH_TMAX_Y:  tmy_ff <= TW'(div_quo);
                  PH_DELTA_Y: dly_ff <= TW'(div_quo);
                  default:    t_ff   <= t_ff;
               endcase
            end
         end
         S_TEST: begin
            if (rd_ff) begin
               hit_ff <= 1'b1;
            end else if (movx || movy) begin
               if (step_x) begin
                  t_ff   <= tmx_ff;
                  tmx_ff <= tmx_ff + dlx_ff;
                  x_ff   <= negx_ff ? (x_ff - 1'b1) : (x_ff + 1'b1);
               end else begin
                  t_ff   <= tmy_ff;
                  tmy_ff <= tmy_ff + dly_ff;
                  y_ff   <= negy_ff ? (y_ff - 1'b1) : (y_ff + 1'b1);
               end
            end
         end
         S_MUL: begin
            prod_ff <= mul_part * mul_mag;
         end
         S_ACC: begin
            if (mstep_ff[1]) begin
               accy_ff <= acc_sum;
            end else begin
               accx_ff <= acc_sum;
            end
         end
         S_END: begin
            endx_ff <= ex[EW-1] ? 16'h0000 : ((ex > $signed(EW'(16'hFFFF))) ? 16'hFFFF : ex[15:0]);
            endy_ff <= ey[EW-1] ? 16'h0000 : ((ey > $signed(EW'(16'hFFFF))) ? 16'hFFFF : ey[15:0]);
         end
         S_OUT: begin
            if (out_free) begin
               rsp_hit_ff   <= hit_ff;
               rsp_end_x_ff <= endx_ff;
               rsp_end_y_ff <= endy_ff;
            end
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   // Tile memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_end_x = rsp_end_x_ff;
   assign rsp_end_y = rsp_end_y_ff;

`ifndef NO_ASSERTIONS
   // No transaction leaves the queue while the map is being cleared.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("queue popped during clearing pass");

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // Divide phases never run past the last one.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVGO) |-> (phase_ff <= PH_DELTA_Y))
      else $error("divide phase out of range");

   // A walk step only follows a map read.
   a_test_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST) |-> ($past(state_ff) == S_READ))
      else $error("map test without read");
`endif

endmodule

FILE: rtl/core/grid_ray_traversal_top.sv
// Channel  Handshake             Payload
// req_     req_valid/req_ready   mode, tile_col, tile_row, tile_solid, origin, dir
// rsp_     rsp_valid/rsp_ready   hit, end_x, end_y
// csr_     csr_we                csr_index, csr_wdata (map_width, map_height)
//
// After reset a clearing pass writes every tile, all MAX_COLS*MAX_ROWS of them (4096 by
// default); req_ready stays low until it ends.
// The back end carries out a write transaction in its idle state as it pops it.
// A cast runs up to four divides, two per axis, on the shared one-bit-per-cycle
// divider; each axis with a zero direction skips its two. Each tile step then
// costs one map read plus one test.
// A two-entry queue separates acceptance from the walk; a result waiting in the
// output register stalls only the back end.
module grid_ray_traversal_top #(
   parameter int TILE_PIXELS = grt_pkg::TILE_PIXELS_DEF,
   parameter int MAX_COLS    = grt_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = grt_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [5:0]                           req_tile_col,
   input  logic [5:0]                           req_tile_row,
   input  logic                                 req_tile_solid,
   input  logic [15:0]                          req_origin_x,
   input  logic [15:0]                          req_origin_y,
   input  logic signed [15:0]                   req_dir_x,
   input  logic signed [15:0]                   req_dir_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic [15:0]                          rsp_end_x,
   output logic [15:0]                          rsp_end_y,
   input  logic                                 csr_we,
   input  logic [grt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [grt_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import grt_pkg::*;

   localparam int WB = $clog2(MAX_COLS + 1);
   localparam int HB = $clog2(MAX_ROWS + 1);

   logic [CSR_DATA_W-1:0] map_width_ff, map_height_ff;
   logic [WB-1:0]         map_cols;
   logic [HB-1:0]         map_rows;
   queue_out_type         q_out;
   logic                  q_pop;
   logic                  clearing;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAP_WIDTH) begin
            map_width_ff <= csr_wdata;
         end else if (csr_index == CSR_MAP_HEIGHT) begin
            map_height_ff <= csr_wdata;
         end
      end
   end

   // Map size in use, limited to the storage.
   assign map_cols = (32'(map_width_ff) < MAX_COLS) ? WB'(map_width_ff) : WB'(MAX_COLS);
   assign map_rows = (32'(map_height_ff) < MAX_ROWS) ? HB'(map_height_ff) : HB'(MAX_ROWS);

   grt_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (clearing),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_tile_col   (req_tile_col),
      .req_tile_row   (req_tile_row),
      .req_tile_solid (req_tile_solid),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .q_out          (q_out),
      .q_pop          (q_pop)
   );

   grt_back #(
      .TILE_PIXELS (TILE_PIXELS),
      .MAX_COLS    (MAX_COLS),
      .MAX_ROWS    (MAX_ROWS),
      .WB          (WB),
      .HB          (HB)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .map_cols  (map_cols),
      .map_rows  (map_rows),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hit   (rsp_hit),
      .rsp_end_x (rsp_end_x),
      .rsp_end_y (rsp_end_y)
   );

endmodule
